/* hdl/rgst_pkg.sv */
`timescale 1ns / 1ps
// Shared package for the range gcd segment tree.
// Holds request codes, value width and default sizes; no dependencies.
package rgst_pkg;

  localparam int VAL_W          = 31;
  localparam int POS_W          = 10;
  localparam int CFG_W          = 11;
  localparam int DEF_MAX_ELEMS  = 1024;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_BUILD = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

endpackage

/* hdl/rgst_ram.sv */
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered; depends on nothing else.
module rgst_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/rgst_gcd.sv */
`timescale 1ns / 1ps
// Iterative binary gcd unit: one shift or subtract step per cycle.
// Depends on rgst_pkg for the value width.
module rgst_gcd
  import rgst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] a_in,
  input  logic [VAL_W-1:0] b_in,
  output logic             done,
  output logic [VAL_W-1:0] result
);

  localparam int K_W = $clog2(VAL_W);

  logic [VAL_W-1:0] a;
  logic [VAL_W-1:0] b;
  logic [K_W-1:0]   k;
  logic             busy;

  // step the operands until one of them reaches zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a    <= a_in;
        b    <= b_in;
        k    <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (a == '0) begin
          result <= b << k;
          busy   <= 1'b0;
          done   <= 1'b1;
        end else if (b == '0) begin
          result <= a << k;
          busy   <= 1'b0;
          done   <= 1'b1;
        end else if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + 1'b1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a >= b) begin
          a <= a - b;
        end else begin
          b <= b - a;
        end
      end
    end
  end

endmodule

/* hdl/range_gcd_segment_tree.sv */
`timescale 1ns / 1ps
// Range gcd segment tree: leaf store and node store in synchronous RAMs.
// Load writes the leaf store directly. Build and query walk the tree with an
// explicit stack, with one binary gcd per merge in the shared gcd unit; a query
// visits about 4*log2(count) nodes.
// Synchronous active-high reset clears control state and sets element_count to 1;
// tree nodes are undefined until a build writes them, no clearing pass is run.
module range_gcd_segment_tree
  import rgst_pkg::*;
#(
  parameter int MAX_ELEMS = DEF_MAX_ELEMS
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // position[9:0], value[40:10], range_low[50:41],
                                // range_high[60:51], zero[63:61]
  input  logic [1:0]  s_tuser,  // req_type[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // gcd_result[30:0], zero[31]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W  = $clog2(MAX_ELEMS);
  localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
  localparam int NODE_D = 4 * MAX_ELEMS;
  localparam int NODE_W = $clog2(NODE_D);
  localparam int SD     = IDX_W + 2;
  localparam int SP_W   = $clog2(SD + 1);
  localparam int SPI_W  = $clog2(SD);
  localparam int CMP_W  = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int SAT_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_VISIT   = 3'd1;
  localparam logic [2:0] ST_NODE_RD = 3'd2;
  localparam logic [2:0] ST_LEAF_RD = 3'd3;
  localparam logic [2:0] ST_RET     = 3'd4;
  localparam logic [2:0] ST_GCD     = 3'd5;

  localparam logic [1:0] PH_FRESH = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;

  // input fields
  logic [1:0]       req_type;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;
  logic [POS_W-1:0] range_low;
  logic [POS_W-1:0] range_high;

  assign req_type   = s_tuser;
  assign position   = s_tdata[9:0];
  assign value      = s_tdata[40:10];
  assign range_low  = s_tdata[50:41];
  assign range_high = s_tdata[60:51];

  // control state
  logic [2:0]       state;
  logic             op_build;
  logic [POS_W-1:0] qlo;
  logic [POS_W-1:0] qhi;
  logic [CNT_W-1:0] element_count;
  logic [VAL_W-1:0] ret;
  logic [SP_W-1:0]  sp;
  logic [VAL_W-1:0] gcd_result;

  // traversal stack
  logic [NODE_W-1:0] stk_node  [SD];
  logic [IDX_W-1:0]  stk_lo    [SD];
  logic [IDX_W-1:0]  stk_hi    [SD];
  logic [1:0]        stk_phase [SD];
  logic [VAL_W-1:0]  stk_left  [SD];

  logic [SPI_W-1:0]  tp;
  logic [SPI_W-1:0]  pp;
  logic [NODE_W-1:0] t_node;
  logic [IDX_W-1:0]  t_lo;
  logic [IDX_W-1:0]  t_hi;
  logic [1:0]        t_phase;
  logic [VAL_W-1:0]  t_left;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  t_mid;
  logic              covered;
  logic              disjoint;

  assign tp      = SPI_W'(sp - 1'b1);
  assign pp      = sp[SPI_W-1:0];
  assign t_node  = stk_node[tp];
  assign t_lo    = stk_lo[tp];
  assign t_hi    = stk_hi[tp];
  assign t_phase = stk_phase[tp];
  assign t_left  = stk_left[tp];
  assign mid_sum = {1'b0, t_lo} + {1'b0, t_hi};
  assign t_mid   = mid_sum[IDX_W:1];
  assign covered  = (CMP_W'(qlo) <= CMP_W'(t_lo)) && (CMP_W'(qhi) >= CMP_W'(t_hi));
  assign disjoint = (CMP_W'(qlo) > CMP_W'(t_hi)) || (CMP_W'(qhi) < CMP_W'(t_lo));

  // memory ports
  logic              node_we;
  logic [VAL_W-1:0]  node_wdata;
  logic [VAL_W-1:0]  node_rdata;
  logic              leaf_we;
  logic [IDX_W-1:0]  leaf_waddr;
  logic [VAL_W-1:0]  leaf_rdata;
  logic              gcd_start;
  logic              gcd_done;
  logic              load_ok;
  logic [CMP_W-1:0]  pos_ext;

  assign pos_ext    = CMP_W'(position);
  assign load_ok    = ({1'b0, pos_ext} < (CMP_W + 1)'(MAX_ELEMS));
  assign leaf_waddr = pos_ext[IDX_W-1:0];
  assign leaf_we    = s_tvalid && s_tready && (req_type == REQ_LOAD) && load_ok;

  assign node_we    = op_build && ((state == ST_LEAF_RD) || (state == ST_GCD && gcd_done));
  assign node_wdata = (state == ST_LEAF_RD) ? leaf_rdata : gcd_result;
  assign gcd_start  = (state == ST_RET) && (sp != '0) && (t_phase == PH_RIGHT);

  rgst_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ELEMS)) u_leaf_ram (
    .clk   (clk),
    .we    (leaf_we),
    .waddr (leaf_waddr),
    .wdata (value),
    .raddr (t_lo),
    .rdata (leaf_rdata)
  );

  rgst_ram #(.WIDTH(VAL_W), .DEPTH(NODE_D)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (t_node),
    .wdata (node_wdata),
    .raddr (t_node),
    .rdata (node_rdata)
  );

  rgst_gcd u_gcd (
    .clk    (clk),
    .rst    (rst),
    .start  (gcd_start),
    .a_in   (t_left),
    .b_in   (ret),
    .done   (gcd_done),
    .result (gcd_result)
  );

  assign s_tready = (state == ST_IDLE);

  // push the query result when the output register is free or draining
  logic res_push;

  assign res_push = (state == ST_RET) && (sp == '0) && !op_build && (!m_tvalid || m_tready);

  // configuration register, saturated to 1..MAX_ELEMS
  logic [SAT_W-1:0] cfg_v;
  logic [SAT_W-1:0] cfg_sat;

  assign cfg_v   = SAT_W'(pwdata[CFG_W-1:0]);
  assign cfg_sat = (cfg_v == '0) ? SAT_W'(1) :
                   (cfg_v > SAT_W'(MAX_ELEMS)) ? SAT_W'(MAX_ELEMS) : cfg_v;
  assign pready  = 1'b1;
  assign prdata  = (paddr == 3'd0) ? 32'(element_count) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= CNT_W'(1);
    end else if (psel && penable && pwrite && paddr == 3'd0) begin
      element_count <= cfg_sat[CNT_W-1:0];
    end
  end

  // tree walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      sp       <= '0;
      m_tvalid <= 1'b0;
      op_build <= 1'b0;
    end else begin
      if (res_push) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && (req_type == REQ_BUILD || req_type == REQ_QUERY)) begin
            op_build      <= (req_type == REQ_BUILD);
            qlo           <= range_low;
            qhi           <= range_high;
            stk_node[0]   <= '0;
            stk_lo[0]     <= '0;
            stk_hi[0]     <= IDX_W'(element_count - 1'b1);
            stk_phase[0]  <= PH_FRESH;
            sp            <= SP_W'(1);
            state         <= ST_VISIT;
          end
        end
        ST_VISIT: begin
          if (op_build && t_lo == t_hi) begin
            state <= ST_LEAF_RD;
          end else if (!op_build && covered) begin
            state <= ST_NODE_RD;
          end else if (!op_build && disjoint) begin
            ret   <= '0;
            sp    <= sp - 1'b1;
            state <= ST_RET;
          end else begin
            // descend into the left child
            stk_phase[tp] <= PH_LEFT;
            stk_node[pp]  <= NODE_W'({t_node, 1'b1});
            stk_lo[pp]    <= t_lo;
            stk_hi[pp]    <= t_mid;
            stk_phase[pp] <= PH_FRESH;
            sp            <= sp + 1'b1;
          end
        end
        ST_NODE_RD: begin
          ret   <= node_rdata;
          sp    <= sp - 1'b1;
          state <= ST_RET;
        end
        ST_LEAF_RD: begin
          ret   <= leaf_rdata;
          sp    <= sp - 1'b1;
          state <= ST_RET;
        end
        ST_RET: begin
          if (sp == '0) begin
            if (op_build) begin
              state <= ST_IDLE;
            end else if (res_push) begin
              m_tdata  <= {1'b0, ret};
              state    <= ST_IDLE;
            end
          end else if (t_phase == PH_LEFT) begin
            // hold the left value and descend into the right child
            stk_left[tp]  <= ret;
            stk_phase[tp] <= PH_RIGHT;
            stk_node[pp]  <= NODE_W'({t_node, 1'b0}) + NODE_W'(2);
            stk_lo[pp]    <= IDX_W'(t_mid + 1'b1);
            stk_hi[pp]    <= t_hi;
            stk_phase[pp] <= PH_FRESH;
            sp            <= sp + 1'b1;
            state         <= ST_VISIT;
          end else begin
            state <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (gcd_done) begin
            ret   <= gcd_result;
            sp    <= sp - 1'b1;
            state <= ST_RET;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_stack_bound: assert property (@(posedge clk) disable iff (rst) sp <= SP_W'(SD))
    else $error("traversal stack overflow");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (sp == '0))
    else $error("stack not empty when idle");
  a_no_write_on_query: assert property (@(posedge clk) disable iff (rst)
    node_we |-> op_build)
    else $error("node store written during a query");
  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !op_build)
    else $error("result raised by a build");
`endif

endmodule
